[src/rga_pkg.sv]
// Shared constants, types and helpers for the regression Gram accumulator.
package rga_pkg;

  localparam int MAX_FEATURES = 16;
  localparam int VALUE_BITS   = 24;
  localparam int SUM_BITS     = 64;
  localparam int PROD_BITS    = 2 * VALUE_BITS;
  localparam int CFG_BITS     = 5;
  localparam int OPCODE_BITS  = 2;
  localparam int ENTRY_BITS   = 8;
  localparam int STORE_DEPTH  = MAX_FEATURES + (MAX_FEATURES * (MAX_FEATURES + 1)) / 2;
  localparam int IDX_BITS     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int USED_BITS    = $clog2(STORE_DEPTH + 1);
  localparam int POS_BITS     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int N_BITS       = $clog2(MAX_FEATURES + 1);
  localparam int CFG_RESET    = 16;

  localparam logic [OPCODE_BITS-1:0] OP_PUSH  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    SEL_RESP,
    SEL_X,
    SEL_BUF
  } rga_sel_t;

  // one read-modify-write request, issued with the store read
  typedef struct packed {
    logic                valid;
    logic [IDX_BITS-1:0] addr;
    rga_sel_t            sel;
    logic                live;
  } rga_issue_t;

  // store write-back
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    logic [SUM_BITS-1:0] data;
    logic                ovf;
  } rga_wr_t;

  // register value clamped to 1..MAX_FEATURES
  function automatic logic [N_BITS-1:0] feat_count(input logic [CFG_BITS-1:0] v);
    int t;
    t = int'(v);
    if (t < 1) t = 1;
    if (t > MAX_FEATURES) t = MAX_FEATURES;
    return N_BITS'(t);
  endfunction

  // entries in use: n X'y sums plus the packed triangle
  function automatic logic [USED_BITS-1:0] used_count(input logic [N_BITS-1:0] n);
    int t;
    t = int'(n);
    t = t + (t * (t + 1)) / 2;
    return USED_BITS'(t);
  endfunction

endpackage

[src/rga_ram.sv]
// Generic simple dual-port RAM with registered read.
module rga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/rga_mac.sv]
// Multiply and saturating accumulate pipeline behind the sum store.
module rga_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  rga_pkg::rga_issue_t                 issue,
  input  logic signed [rga_pkg::VALUE_BITS-1:0] x,
  input  logic signed [rga_pkg::VALUE_BITS-1:0] resp,
  input  logic [rga_pkg::SUM_BITS-1:0]        store_rdata,
  input  logic signed [rga_pkg::VALUE_BITS-1:0] buf_rdata,
  output rga_pkg::rga_wr_t                    wr,
  output logic                                pend
);
  import rga_pkg::*;

  logic                       s1_valid;
  logic [IDX_BITS-1:0]        s1_addr;
  rga_sel_t                   s1_sel;
  logic                       s1_live;
  logic                       s2_valid;
  logic [IDX_BITS-1:0]        s2_addr;
  logic signed [PROD_BITS-1:0] s2_prod;
  logic signed [SUM_BITS-1:0] s2_old;

  logic signed [VALUE_BITS-1:0] operand;
  logic signed [SUM_BITS-1:0]   addend;
  logic signed [SUM_BITS-1:0]   sum;
  logic                         ovf;

  always_comb begin
    case (s1_sel)
      SEL_RESP: operand = resp;
      SEL_X:    operand = x;
      SEL_BUF:  operand = buf_rdata;
      default:  operand = buf_rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue.valid;
      s2_valid <= s1_valid;
    end
    s1_addr <= issue.addr;
    s1_sel  <= issue.sel;
    s1_live <= issue.live;
    s2_addr <= s1_addr;
    s2_prod <= operand * x;
    // never-written entries count as zero
    s2_old  <= s1_live ? signed'(store_rdata) : '0;
  end

  assign addend = SUM_BITS'(s2_prod);
  assign sum    = s2_old + addend;
  assign ovf    = (s2_old[SUM_BITS-1] == addend[SUM_BITS-1]) &&
                  (sum[SUM_BITS-1] != s2_old[SUM_BITS-1]);

  always_comb begin
    wr.en   = s2_valid;
    wr.addr = s2_addr;
    wr.ovf  = s2_valid && ovf;
    if (!ovf) begin
      wr.data = sum;
    end else if (s2_old[SUM_BITS-1]) begin
      wr.data = {1'b1, {(SUM_BITS-1){1'b0}}};
    end else begin
      wr.data = {1'b0, {(SUM_BITS-1){1'b1}}};
    end
  end

  assign pend = s1_valid || s2_valid;

endmodule

[src/regression_gram_accumulator.sv]
// Regression normal-equation accumulator: X'y and packed X'X sums in one store.
//
// Push element p of a row (p counts from 0) and busy stays high while the
// sequencer issues p+2 read-modify-writes to the sum store, one per cycle (the
// X'y sum, then triangle entries (0,p)..(p,p)), and until the multiply and
// saturating-add stages have drained. A read keeps busy high for one cycle;
// done pulses for one cycle in the cycle after with entry_value and saturated,
// and the result cannot be held off. A clear takes effect in the cycle it is
// accepted and leaves busy low. Sums are Q40.24 and saturate; the saturated
// flag is sticky until a clear. cfg_ready is high only while busy and start
// are both low, and a write restarts the current row.
module regression_gram_accumulator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rga_pkg::OPCODE_BITS-1:0]       opcode,
  input  logic signed [rga_pkg::VALUE_BITS-1:0] x_value,
  input  logic signed [rga_pkg::VALUE_BITS-1:0] y_value,
  input  logic [rga_pkg::ENTRY_BITS-1:0]        entry_index,
  output logic                                  done,
  output logic signed [rga_pkg::SUM_BITS-1:0]   entry_value,
  output logic                                  saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rga_pkg::CFG_BITS-1:0]          cfg_num_features
);
  import rga_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ
  } state_t;

  state_t                       state;
  logic [CFG_BITS-1:0]          num_features;
  logic [POS_BITS-1:0]          pos;
  logic signed [VALUE_BITS-1:0] resp;
  logic signed [VALUE_BITS-1:0] x_reg;
  logic [POS_BITS-1:0]          p_reg;
  logic [N_BITS-1:0]            k;
  logic [IDX_BITS-1:0]          tri_addr;
  logic [STORE_DEPTH-1:0]       live;
  logic                         overflow;
  logic                         rd_ok;

  logic [N_BITS-1:0]     n_eff;
  logic [USED_BITS-1:0]  used;
  logic                  accept;
  logic [POS_BITS-1:0]   p_start;
  logic [N_BITS-1:0]     p_next;
  logic [POS_BITS-1:0]   row_i;
  logic                  last_issue;
  logic [IDX_BITS-1:0]   rd_addr;
  logic                  in_range;
  rga_issue_t            issue;
  rga_wr_t               wr;
  logic                  pend;
  logic [SUM_BITS-1:0]   store_rdata;
  logic [VALUE_BITS-1:0] buf_rdata;

  assign n_eff     = feat_count(num_features);
  assign used      = used_count(n_eff);
  assign busy      = (state != ST_IDLE) || pend;
  // hold off a register write while a command beat is offered
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;

  assign p_start    = (N_BITS'(pos) >= n_eff) ? '0 : pos;
  assign p_next     = N_BITS'(p_start) + N_BITS'(1);
  assign row_i      = POS_BITS'(k - N_BITS'(1));
  assign last_issue = (k == N_BITS'(p_reg) + N_BITS'(1));
  assign in_range   = (int'(entry_index) < int'(used));

  always_comb begin
    issue.valid = (state == ST_PUSH);
    issue.sel   = SEL_RESP;
    issue.addr  = IDX_BITS'(p_reg);
    if (state == ST_PUSH && k != '0) begin
      issue.addr = tri_addr;
      // on its own diagonal the current element is taken from x_reg, not the row buffer
      issue.sel  = (row_i == p_reg) ? SEL_X : SEL_BUF;
    end
    rd_addr    = (state == ST_PUSH) ? issue.addr : IDX_BITS'(entry_index);
    issue.live = live[rd_addr];
  end

  rga_ram #(
    .WIDTH(SUM_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .raddr(rd_addr),
    .rdata(store_rdata)
  );

  rga_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_FEATURES)
  ) u_row_buf (
    .clk  (clk),
    .we   (state == ST_PUSH && k == '0),
    .waddr(p_reg),
    .wdata(x_reg),
    .raddr(row_i),
    .rdata(buf_rdata)
  );

  rga_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .x          (x_reg),
    .resp       (resp),
    .store_rdata(store_rdata),
    .buf_rdata  (signed'(buf_rdata)),
    .wr         (wr),
    .pend       (pend)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      num_features <= CFG_BITS'(CFG_RESET);
      pos          <= '0;
      resp         <= '0;
      live         <= '0;
      overflow     <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr.en) begin
        live[wr.addr] <= 1'b1;
      end
      if (wr.ovf) begin
        overflow <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        num_features <= cfg_num_features;
        pos          <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_PUSH: begin
                x_reg    <= x_value;
                p_reg    <= p_start;
                k        <= '0;
                tri_addr <= IDX_BITS'(n_eff) + IDX_BITS'(p_start);
                if (p_start == '0) begin
                  resp <= y_value;
                end
                pos   <= (p_next >= n_eff) ? '0 : POS_BITS'(p_next);
                state <= ST_PUSH;
              end
              OP_READ: begin
                rd_ok <= in_range && issue.live;
                state <= ST_READ;
              end
              OP_CLEAR: begin
                live     <= '0;
                overflow <= 1'b0;
                pos      <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PUSH: begin
          k <= k + N_BITS'(1);
          if (k != '0) begin
            // advance to entry (i+1, p): rows shrink by one each step
            tri_addr <= tri_addr + IDX_BITS'(n_eff) - IDX_BITS'(1) - IDX_BITS'(row_i);
          end
          if (last_issue) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          entry_value <= rd_ok ? signed'(store_rdata) : '0;
          saturated   <= overflow;
          done        <= 1'b1;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/regression_gram_accumulator_tb.sv]
// Self-checking testbench for the regression Gram accumulator.
`timescale 1ns / 100ps
module regression_gram_accumulator_tb;
  import rga_pkg::*;

  localparam logic [OPCODE_BITS-1:0] OP_IGNORED = 2'd3;
  localparam int SETTLE_CYCLES = MAX_FEATURES + 8;
  localparam int CYCLE_LIMIT = 4000000;
  // pushes of the largest square product: large sums, still well inside the limits
  localparam int LARGE_PUSHES = 40;
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};

  typedef struct packed {
    logic [SUM_BITS-1:0] value;
    logic                sat;
  } readback_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [OPCODE_BITS-1:0]        opcode = OP_PUSH;
  logic signed [VALUE_BITS-1:0]  x_value = '0;
  logic signed [VALUE_BITS-1:0]  y_value = '0;
  logic [ENTRY_BITS-1:0]         entry_index = '0;
  logic                          done;
  logic signed [SUM_BITS-1:0]    entry_value;
  logic                          saturated;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_BITS-1:0]           cfg_num_features = CFG_BITS'(CFG_RESET);

  // mirror of the accumulator state
  logic signed [SUM_BITS-1:0]    sum_mirror [STORE_DEPTH];
  logic signed [VALUE_BITS-1:0]  row_elems [MAX_FEATURES];
  int unsigned                   row_pos = 0;
  logic signed [VALUE_BITS-1:0]  row_resp = '0;
  logic                          sat_flag = 1'b0;
  logic [CFG_BITS-1:0]           features_reg = CFG_BITS'(CFG_RESET);

  readback_t                     pending_reads [$];
  int unsigned                   mismatch_count = 0;
  int unsigned                   cycle_count = 0;
  int unsigned                   gap_pct = 0;

  regression_gram_accumulator u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("regression_gram_accumulator_tb failed");
      $finish;
    end
  end

  function automatic int unsigned active_features();
    int unsigned n;
    n = 32'(features_reg);
    if (n < 1) n = 1;
    if (n > MAX_FEATURES) n = MAX_FEATURES;
    return n;
  endfunction

  function automatic int unsigned triangle_slot(input int unsigned n, input int unsigned i,
                                                input int unsigned j);
    return n + (i * (2 * n - i + 1)) / 2 + (j - i);
  endfunction

  function automatic logic signed [SUM_BITS-1:0] exact_product(
      input logic signed [VALUE_BITS-1:0] a, input logic signed [VALUE_BITS-1:0] b);
    logic signed [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(a) * PROD_BITS'(b);
    return {{(SUM_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
  endfunction

  task automatic add_saturating(input int unsigned idx, input logic signed [SUM_BITS-1:0] term);
    logic [SUM_BITS:0] total;
    total = {sum_mirror[idx][SUM_BITS-1], sum_mirror[idx]} + {term[SUM_BITS-1], term};
    if (total[SUM_BITS] != total[SUM_BITS-1]) begin
      sum_mirror[idx] = total[SUM_BITS] ? SUM_MIN : SUM_MAX;
      sat_flag = 1'b1;
    end else begin
      sum_mirror[idx] = total[SUM_BITS-1:0];
    end
  endtask

  task automatic gram_push(input logic signed [VALUE_BITS-1:0] x,
                           input logic signed [VALUE_BITS-1:0] y);
    int unsigned n;
    int unsigned p;
    int unsigned i;
    n = active_features();
    p = row_pos;
    if (p >= n) p = 0;
    // latch the response on the first element of a row
    if (p == 0) row_resp = y;
    row_elems[p] = x;
    add_saturating(p, exact_product(row_resp, x));
    for (i = 0; i <= p; i++) add_saturating(triangle_slot(n, i, p), exact_product(row_elems[i], x));
    p++;
    row_pos = (p >= n) ? 0 : p;
  endtask

  task automatic gram_read(input logic [ENTRY_BITS-1:0] idx);
    int unsigned n;
    int unsigned used;
    readback_t r;
    n = active_features();
    used = n + (n * (n + 1)) / 2;
    r.value = (32'(idx) < used) ? sum_mirror[idx] : '0;
    r.sat = sat_flag;
    pending_reads.push_back(r);
  endtask

  task automatic gram_clear();
    int unsigned i;
    for (i = 0; i < STORE_DEPTH; i++) sum_mirror[i] = '0;
    sat_flag = 1'b0;
    row_pos = 0;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    logic [31:0] r;
    case ($urandom_range(9))
      0: r = {{(32-VALUE_BITS){1'b1}}, VAL_MIN};
      1: r = {{(32-VALUE_BITS){1'b0}}, VAL_MAX};
      2: begin
        r = $urandom_range(8);
        r = r - 32'd4;
      end
      default: r = $urandom;
    endcase
    return r[VALUE_BITS-1:0];
  endfunction

  function automatic logic [ENTRY_BITS-1:0] rand_index();
    int unsigned n;
    int unsigned used;
    n = active_features();
    used = n + (n * (n + 1)) / 2;
    if ($urandom_range(4) == 0) return ENTRY_BITS'($urandom_range(STORE_DEPTH - 1));
    return ENTRY_BITS'($urandom_range(used - 1));
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_features();
    logic [31:0] r;
    case ($urandom_range(7))
      0: r = 32'd0;
      1: r = 32'd31;
      2: r = 32'd16;
      3: r = 32'd17;
      default: r = $urandom_range(1, 6);
    endcase
    return r[CFG_BITS-1:0];
  endfunction

  // send one command beat and update the mirror when it is taken
  task automatic send_item(input logic [OPCODE_BITS-1:0] op,
                           input logic signed [VALUE_BITS-1:0] x,
                           input logic signed [VALUE_BITS-1:0] y,
                           input logic [ENTRY_BITS-1:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    x_value <= x;
    y_value <= y;
    entry_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      OP_PUSH:  gram_push(x, y);
      OP_READ:  gram_read(idx);
      OP_CLEAR: gram_clear();
      default: ;
    endcase
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    // pushes give no result: let the last one finish
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_features(input logic [CFG_BITS-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_num_features <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    features_reg = v;
    row_pos = 0;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_readback
    readback_t want;
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result, entry_value %0d saturated %0b",
                 $time, entry_value, saturated);
        mismatch_count++;
      end else begin
        want = pending_reads.pop_front();
        if (entry_value !== want.value) begin
          $display("%0t: entry_value mismatch, expected %0d, actual %0d",
                   $time, $signed(want.value), entry_value);
          mismatch_count++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated mismatch, expected %0b, actual %0b",
                   $time, want.sat, saturated);
          mismatch_count++;
        end
      end
    end
  end

  // full row at the reset width with extreme elements, reads, ignored opcode, clear
  task automatic test_extremes();
    int unsigned i;
    logic signed [VALUE_BITS-1:0] x;
    gap_pct = 0;
    for (i = 0; i < MAX_FEATURES; i++) begin
      case (i % 3)
        0: x = VAL_MIN;
        1: x = VAL_MAX;
        default: x = VALUE_BITS'(int'(i) - 8);
      endcase
      send_item(OP_PUSH, x, (i == 0) ? VAL_MIN : VAL_MAX, '0);
    end
    send_item(OP_READ, VAL_MAX, VAL_MIN, '0);
    send_item(OP_READ, '0, '0, ENTRY_BITS'(MAX_FEATURES));
    send_item(OP_READ, VAL_MIN, VAL_MAX, ENTRY_BITS'(STORE_DEPTH - 1));
    send_item(OP_IGNORED, VAL_MAX, VAL_MAX, '1);
    send_item(OP_CLEAR, VAL_MIN, VAL_MIN, '1);
    send_item(OP_READ, '0, '0, ENTRY_BITS'(STORE_DEPTH - 1));
  endtask

  // clamping of the feature count, row dropped on a write, read past the used entries
  task automatic test_feature_limits();
    write_features('1);
    send_item(OP_PUSH, VAL_MAX, VAL_MAX, '0);
    send_item(OP_PUSH, VAL_MIN, VAL_MIN, '0);
    write_features('0);
    send_item(OP_PUSH, VAL_MAX, VAL_MIN, '0);
    send_item(OP_READ, '0, '0, ENTRY_BITS'(1));
    send_item(OP_READ, '0, '0, ENTRY_BITS'(2));
  endtask

  // pile the largest products into both sums of a one-feature row, read back, then clear
  task automatic test_large_sums();
    int unsigned i;
    gap_pct = 0;
    write_features(CFG_BITS'(1));
    send_item(OP_CLEAR, '0, '0, '0);
    for (i = 0; i < LARGE_PUSHES; i++) send_item(OP_PUSH, VAL_MIN, VAL_MAX, '0);
    send_item(OP_READ, '0, '0, ENTRY_BITS'(1));
    for (i = 0; i < 3; i++) send_item(OP_PUSH, VAL_MIN, VAL_MAX, '0);
    send_item(OP_READ, '0, '0, ENTRY_BITS'(0));
    send_item(OP_READ, '0, '0, ENTRY_BITS'(1));
    send_item(OP_PUSH, VALUE_BITS'(1), VALUE_BITS'(-1), '0);
    send_item(OP_PUSH, VALUE_BITS'(3), VALUE_BITS'(5), '0);
    send_item(OP_READ, '0, '0, ENTRY_BITS'(0));
    send_item(OP_READ, '0, '0, ENTRY_BITS'(1));
    send_item(OP_READ, '0, '0, ENTRY_BITS'(2));
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_READ, '0, '0, ENTRY_BITS'(1));
  endtask

  // mostly complete rows with random content, mixed with reads, clears, feature writes and noise
  task automatic test_random_rows(input int unsigned items, input int unsigned gap);
    int unsigned sent;
    int unsigned n;
    int unsigned len;
    int unsigned k;
    gap_pct = gap;
    write_features(pick_features());
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(39))
        0: write_features(pick_features());
        1: begin
          send_item(OP_CLEAR, rand_value(), rand_value(), rand_index());
          sent++;
        end
        2: send_item(OP_IGNORED, rand_value(), rand_value(), rand_index());
        3: drain_results();
        4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
          for (k = $urandom_range(1, 4); k > 0; k--) begin
            send_item(OP_READ, rand_value(), rand_value(), rand_index());
            sent++;
          end
        end
        default: begin
          n = active_features();
          len = ($urandom_range(9) == 0) ? $urandom_range(1, n) : n;
          for (k = 0; k < len; k++) begin
            send_item(OP_PUSH, rand_value(), rand_value(), rand_index());
            sent++;
            if ($urandom_range(99) < 15) begin
              send_item(OP_READ, rand_value(), rand_value(), rand_index());
              sent++;
            end
          end
        end
      endcase
    end
  endtask

  initial begin : run_tests
    int unsigned i;
    for (i = 0; i < STORE_DEPTH; i++) sum_mirror[i] = '0;
    for (i = 0; i < MAX_FEATURES; i++) row_elems[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_feature_limits();
    test_large_sums();
    test_random_rows(600, 10);
    test_random_rows(600, 77);
    test_random_rows(600, 0);
    drain_results();
    if (mismatch_count == 0 && pending_reads.size() == 0) begin
      $display("regression_gram_accumulator_tb passed");
    end else begin
      $display("regression_gram_accumulator_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/rga_pkg.sv
src/rga_ram.sv
src/rga_mac.sv
src/regression_gram_accumulator.sv
tb/regression_gram_accumulator_tb.sv
